>>> rtl/rrpq_pkg.sv
// Package with shared constants and types for the response ratio priority queue.
`default_nettype none
package rrpq_pkg;
   localparam int DefTableDepth = 16;
   localparam int IdWidth = 16;
   localparam int TimeWidth = 48;
   localparam int BurstWidth = 32;
   localparam int StatusWidth = 3;
   localparam int OccWidth = 5;

   localparam logic [1:0] ActInsert = 2'd0;
   localparam logic [1:0] ActRemove = 2'd1;
   localparam logic [1:0] ActPick = 2'd2;
   localparam logic [1:0] ActUnused = 2'd3;

   localparam logic [StatusWidth-1:0] StOk = 3'd0;
   localparam logic [StatusWidth-1:0] StFull = 3'd1;
   localparam logic [StatusWidth-1:0] StNotFound = 3'd2;
   localparam logic [StatusWidth-1:0] StEmpty = 3'd3;
   localparam logic [StatusWidth-1:0] StZeroBurst = 3'd4;

   // Control broadcast to every cell of the table.
   typedef struct packed {
      logic ins;
      logic rem;
      logic [IdWidth-1:0] key_id;
      logic [TimeWidth-1:0] key_ratio;
   } cell_ctl_type;
endpackage
`default_nettype wire

>>> rtl/rrpq_if.sv
// Request and response channel interfaces.
`default_nettype none
interface rrpq_req_if;
   logic valid;
   logic ready;
   logic [1:0] action;
   logic [15:0] task_id;
   logic [47:0] now_time;
   logic [47:0] arrive_ns;
   logic [31:0] service_ns;
   modport source (output valid, action, task_id, now_time, arrive_ns, service_ns,
                   input ready);
   modport sink (input valid, action, task_id, now_time, arrive_ns, service_ns,
                 output ready);
endinterface

interface rrpq_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] status;
   logic [15:0] picked_id;
   logic [47:0] picked_ratio;
   logic [4:0] occupancy;
   modport source (output valid, status, picked_id, picked_ratio, occupancy, input ready);
   modport sink (input valid, status, picked_id, picked_ratio, occupancy, output ready);
endinterface
`default_nettype wire

>>> rtl/rrpq_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rrpq_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [rrpq_pkg::TimeWidth-1:0] dividend,
   input  wire logic [rrpq_pkg::BurstWidth-1:0] divisor,
   output logic done,
   output logic [rrpq_pkg::TimeWidth-1:0] quotient
);
   import rrpq_pkg::*;
   localparam int CntWidth = $clog2(TimeWidth + 1);

   logic [TimeWidth-1:0] quo_ff, quo_in;
   logic [BurstWidth:0] rem_ff, rem_in;
   logic [BurstWidth-1:0] dsr_ff, dsr_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [BurstWidth:0] trial;

   // One shift and trial subtract per cycle.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[BurstWidth-1:0], quo_ff[TimeWidth-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CntWidth'(TimeWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[TimeWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[TimeWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

>>> rtl/rrpq_cell.sv
// One slot of the sorted table; shifts with its neighbors on insert and remove.
`default_nettype none
module rrpq_cell (
   input  wire logic clock,
   input  wire logic reset,
   input  wire rrpq_pkg::cell_ctl_type ctl,
   input  wire logic left_valid,
   input  wire logic [rrpq_pkg::IdWidth-1:0] left_task,
   input  wire logic [rrpq_pkg::TimeWidth-1:0] left_ratio,
   input  wire logic left_keep,
   input  wire logic left_seen,
   input  wire logic right_valid,
   input  wire logic [rrpq_pkg::IdWidth-1:0] right_task,
   input  wire logic [rrpq_pkg::TimeWidth-1:0] right_ratio,
   output logic valid,
   output logic [rrpq_pkg::IdWidth-1:0] task_id,
   output logic [rrpq_pkg::TimeWidth-1:0] ratio,
   output logic keep,
   output logic seen
);
   import rrpq_pkg::*;

   logic valid_ff, valid_in;
   logic [IdWidth-1:0] task_ff, task_in;
   logic [TimeWidth-1:0] ratio_ff, ratio_in;
   logic match;

   assign keep = valid_ff && (ratio_ff >= ctl.key_ratio);
   assign match = valid_ff && (task_ff == ctl.key_id);
   assign seen = left_seen || match;

   // Insert shifts right past the kept prefix; remove shifts left from the match.
   always_comb begin
      valid_in = valid_ff;
      task_in = task_ff;
      ratio_in = ratio_ff;
      if (ctl.ins && !keep) begin
         if (left_keep) begin
            valid_in = 1'b1;
            task_in = ctl.key_id;
            ratio_in = ctl.key_ratio;
         end else begin
            valid_in = left_valid;
            task_in = left_task;
            ratio_in = left_ratio;
         end
      end else if (ctl.rem && seen) begin
         valid_in = right_valid;
         task_in = right_task;
         ratio_in = right_ratio;
      end
   end

   always_ff @(posedge clock) begin
      task_ff <= task_in;
      ratio_ff <= ratio_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign valid = valid_ff;
   assign task_id = task_ff;
   assign ratio = ratio_ff;
endmodule
`default_nettype wire

>>> rtl/response_ratio_priority_queue.sv
// Top level of the response ratio priority queue: sequencer, divider and cell row.
//
// Usage: requests arrive on req_chan (valid/ready) carrying an action, a task id,
// the current time, the arrival time and the expected service time. Every request
// yields exactly one response on rsp_chan with a status, the picked id, a ratio and
// the table occupancy after the action.
// An insert with a nonzero burst into a table that is not full runs the serial
// divider over all 48 dividend bits; its response is registered once the divider
// is done and the apply state has updated the row.
// Remove, pick, rejected inserts and unused actions skip the divider and go from
// the apply state straight into the response register. The cell row updates all
// slots together in the apply state.
// One request is worked on at a time; the next is taken once the response
// register is free or is being taken in the same cycle.
// Reset empties the table (all slot valid bits clear) and drops any response.
// When the receiver stalls, the response holds and no new request is taken.
`default_nettype none
module response_ratio_priority_queue #(
   parameter int TABLE_DEPTH = rrpq_pkg::DefTableDepth
) (
   input wire logic clock,
   input wire logic reset,
   rrpq_req_if.sink req_chan,
   rrpq_rsp_if.source rsp_chan
);
   import rrpq_pkg::*;
   localparam int CntWidth = $clog2(TABLE_DEPTH + 1);
   localparam logic [1:0] SIdle = 2'd0;
   localparam logic [1:0] SDiv = 2'd1;
   localparam logic [1:0] SApply = 2'd2;
   localparam logic [TimeWidth-1:0] MaxRatio = {TimeWidth{1'b1}};

   logic [1:0] state_ff, state_in;
   logic [1:0] act_ff;
   logic [IdWidth-1:0] id_ff;
   logic bad_burst_ff;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic rv_ff, rv_in;
   logic [StatusWidth-1:0] st_ff, st_in;
   logic [IdWidth-1:0] pid_ff, pid_in;
   logic [TimeWidth-1:0] prat_ff, prat_in;

   logic accept, div_done;
   logic [TimeWidth-1:0] waiting, quotient, new_ratio;
   logic full;
   cell_ctl_type ctl;

   logic [TABLE_DEPTH-1:0] c_valid, c_keep, c_seen;
   logic [IdWidth-1:0] c_task [TABLE_DEPTH];
   logic [TimeWidth-1:0] c_ratio [TABLE_DEPTH];

   assign req_chan.ready = (state_ff == SIdle) && (!rv_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;
   assign waiting = (req_chan.now_time >= req_chan.arrive_ns) ?
                    req_chan.now_time - req_chan.arrive_ns : '0;
   assign full = (cnt_ff == CntWidth'(TABLE_DEPTH));
   assign new_ratio = (quotient == MaxRatio) ? MaxRatio : quotient + 1'b1;

   rrpq_div u_div (
      .clock(clock),
      .reset(reset),
      .start(accept && (req_chan.action == ActInsert) &&
             (req_chan.service_ns != '0) && !full),
      .dividend(waiting),
      .divisor(req_chan.service_ns),
      .done(div_done),
      .quotient(quotient)
   );

   // Broadcast to the row during the apply cycle.
   always_comb begin
      ctl.ins = (state_ff == SApply) && (act_ff == ActInsert) && !bad_burst_ff && !full;
      ctl.rem = (state_ff == SApply) && (act_ff == ActRemove);
      ctl.key_id = id_ff;
      ctl.key_ratio = new_ratio;
   end

   // Row of cells, each linked to both neighbors.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic lv, lk, ls, rv;
      logic [IdWidth-1:0] lt, rt;
      logic [TimeWidth-1:0] lr, rr;
      if (i == 0) begin : g_first
         assign lv = 1'b0;
         assign lt = '0;
         assign lr = '0;
         assign lk = 1'b1;
         assign ls = 1'b0;
      end else begin : g_mid
         assign lv = c_valid[i-1];
         assign lt = c_task[i-1];
         assign lr = c_ratio[i-1];
         assign lk = c_keep[i-1];
         assign ls = c_seen[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign rv = 1'b0;
         assign rt = '0;
         assign rr = '0;
      end else begin : g_inner
         assign rv = c_valid[i+1];
         assign rt = c_task[i+1];
         assign rr = c_ratio[i+1];
      end
      rrpq_cell u_cell (
         .clock(clock),
         .reset(reset),
         .ctl(ctl),
         .left_valid(lv),
         .left_task(lt),
         .left_ratio(lr),
         .left_keep(lk),
         .left_seen(ls),
         .right_valid(rv),
         .right_task(rt),
         .right_ratio(rr),
         .valid(c_valid[i]),
         .task_id(c_task[i]),
         .ratio(c_ratio[i]),
         .keep(c_keep[i]),
         .seen(c_seen[i])
      );
   end

   // Sequencer and response register.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rv_in = rv_ff;
      st_in = st_ff;
      pid_in = pid_ff;
      prat_in = prat_ff;
      if (rv_ff && rsp_chan.ready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         SIdle: begin
            if (accept) begin
               if ((req_chan.action == ActInsert) && (req_chan.service_ns != '0) && !full) begin
                  state_in = SDiv;
               end else begin
                  state_in = SApply;
               end
            end
         end
         SDiv: begin
            if (div_done) begin
               state_in = SApply;
            end
         end
         SApply: begin
            state_in = SIdle;
            rv_in = 1'b1;
            st_in = StOk;
            pid_in = '0;
            prat_in = '0;
            case (act_ff)
               ActInsert: begin
                  if (bad_burst_ff) begin
                     st_in = StZeroBurst;
                  end else if (full) begin
                     st_in = StFull;
                  end else begin
                     prat_in = new_ratio;
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               ActRemove: begin
                  if (c_seen[TABLE_DEPTH-1]) begin
                     cnt_in = cnt_ff - 1'b1;
                  end else begin
                     st_in = StNotFound;
                  end
               end
               ActPick: begin
                  if (c_valid[0]) begin
                     pid_in = c_task[0];
                     prat_in = c_ratio[0];
                  end else begin
                     st_in = StEmpty;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = SIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_chan.action;
         id_ff <= req_chan.task_id;
         bad_burst_ff <= (req_chan.service_ns == '0);
      end
      st_ff <= st_in;
      pid_ff <= pid_in;
      prat_ff <= prat_in;
      if (reset) begin
         state_ff <= SIdle;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
      end
   end

   assign rsp_chan.valid = rv_ff;
   assign rsp_chan.status = st_ff;
   assign rsp_chan.picked_id = pid_ff;
   assign rsp_chan.picked_ratio = prat_ff;
   assign rsp_chan.occupancy = OccWidth'(cnt_ff);
endmodule
`default_nettype wire

>>> tb/tb_response_ratio_priority_queue.sv
// Self-checking testbench for the response ratio priority queue.
`timescale 1ns / 1ps
module tb_response_ratio_priority_queue;
   import rrpq_pkg::*;

   localparam int Depth = DefTableDepth;
   localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
   localparam int StallLimit = 2000;

   typedef struct packed {
      logic [1:0] action;
      logic [15:0] task_id;
      logic [47:0] now_time;
      logic [47:0] arrive_ns;
      logic [31:0] service_ns;
   } request_type;

   typedef struct packed {
      logic [2:0] status;
      logic [15:0] picked_id;
      logic [47:0] picked_ratio;
      logic [4:0] occupancy;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rrpq_req_if req_chan ();
   rrpq_rsp_if rsp_chan ();

   response_ratio_priority_queue #(.TABLE_DEPTH(Depth)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #5 clock = ~clock;

   // Shadow copy of the ready table, sorted highest ratio first.
   logic [15:0] shadow_id[Depth];
   logic [47:0] shadow_ratio[Depth];
   int shadow_count = 0;

   request_type pending_requests[$];
   response_type expected_responses[$];
   int errors = 0;
   int accepted = 0;
   int checked = 0;
   int rejects = 0;
   int idle_cycles = 0;

   // Ratio is the quotient plus one, waiting time saturating at zero, sum saturating at 48 bits.
   function automatic logic [47:0] response_ratio(logic [47:0] now_t, logic [47:0] arr_t,
                                                  logic [31:0] burst);
      logic [47:0] waiting;
      logic [47:0] quotient;
      waiting = (now_t >= arr_t) ? now_t - arr_t : 48'd0;
      quotient = waiting / {16'd0, burst};
      if (quotient >= Max48) return Max48;
      return quotient + 48'd1;
   endfunction

   // Applies one request to the shadow table and returns the response it causes.
   function automatic response_type apply_request(request_type rq);
      response_type rs;
      int pos;
      logic [47:0] r;
      rs = '0;
      if (rq.action == ActInsert) begin
         if (rq.service_ns == 0) begin
            rs.status = StZeroBurst;
         end else if (shadow_count >= Depth) begin
            rs.status = StFull;
         end else begin
            r = response_ratio(rq.now_time, rq.arrive_ns, rq.service_ns);
            pos = 0;
            while (pos < shadow_count && shadow_ratio[pos] >= r) pos++;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_id[i] = shadow_id[i-1];
               shadow_ratio[i] = shadow_ratio[i-1];
            end
            shadow_id[pos] = rq.task_id;
            shadow_ratio[pos] = r;
            shadow_count++;
            rs.picked_ratio = r;
         end
      end else if (rq.action == ActRemove) begin
         pos = 0;
         while (pos < shadow_count && shadow_id[pos] != rq.task_id) pos++;
         if (pos >= shadow_count) begin
            rs.status = StNotFound;
         end else begin
            for (int i = pos; i + 1 < shadow_count; i++) begin
               shadow_id[i] = shadow_id[i+1];
               shadow_ratio[i] = shadow_ratio[i+1];
            end
            shadow_count--;
         end
      end else if (rq.action == ActPick) begin
         if (shadow_count == 0) begin
            rs.status = StEmpty;
         end else begin
            rs.picked_id = shadow_id[0];
            rs.picked_ratio = shadow_ratio[0];
         end
      end
      rs.occupancy = 5'(shadow_count);
      return rs;
   endfunction

   function automatic request_type make_request(logic [1:0] act, logic [15:0] id,
                                                logic [47:0] now_t, logic [47:0] arr_t,
                                                logic [31:0] burst);
      request_type rq;
      rq.action = act;
      rq.task_id = id;
      rq.now_time = now_t;
      rq.arrive_ns = arr_t;
      rq.service_ns = burst;
      return rq;
   endfunction

   function automatic logic [47:0] rand48();
      return {16'($urandom), $urandom};
   endfunction

   // Driver: takes pending requests in order with a random gap before each.
   int send_gap = 0;
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap <= $urandom_range(0, 3);
      end else if (req_chan.valid && !req_chan.ready) begin
         // Hold the request until it is taken.
      end else begin
         gap = send_gap;
         if (req_chan.valid) begin
            expected_responses.push_back(apply_request(pending_requests.pop_front()));
            accepted++;
            gap = $urandom_range(0, 3);
         end
         if (gap > 0 || pending_requests.size() == 0) begin
            req_chan.valid <= 1'b0;
            send_gap <= (gap > 0) ? gap - 1 : 0;
         end else begin
            req_chan.valid <= 1'b1;
            {req_chan.action, req_chan.task_id, req_chan.now_time,
             req_chan.arrive_ns, req_chan.service_ns} <= pending_requests[0];
            send_gap <= 0;
         end
      end
   end

   // Monitor: compares each response with the oldest expectation.
   int stall_left = 0;
   always @(posedge clock) begin
      response_type act;
      response_type exp_rs;
      int stall;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            act = {rsp_chan.status, rsp_chan.picked_id, rsp_chan.picked_ratio,
                   rsp_chan.occupancy};
            if (expected_responses.size() == 0) begin
               $display("%0t: unexpected response %h", $time, act);
               errors++;
            end else begin
               exp_rs = expected_responses.pop_front();
               checked++;
               if (act.status != exp_rs.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, exp_rs.status,
                           act.status);
                  errors++;
               end
               if (act.picked_id != exp_rs.picked_id) begin
                  $display("%0t: picked_id expected %h actual %h", $time,
                           exp_rs.picked_id, act.picked_id);
                  errors++;
               end
               if (act.picked_ratio != exp_rs.picked_ratio) begin
                  $display("%0t: picked_ratio expected %h actual %h", $time,
                           exp_rs.picked_ratio, act.picked_ratio);
                  errors++;
               end
               if (act.occupancy != exp_rs.occupancy) begin
                  $display("%0t: occupancy expected %0d actual %0d", $time,
                           exp_rs.occupancy, act.occupancy);
                  errors++;
               end
               if (exp_rs.status != StOk) rejects++;
            end
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= (stall_left == 1);
            stall_left <= stall_left - 1;
         end else if (rsp_chan.valid && rsp_chan.ready) begin
            stall = $urandom_range(0, 3);
            rsp_chan.ready <= (stall == 0);
            stall_left <= stall;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (req_chan.valid || expected_responses.size() != 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("%0t: no progress", $time);
            $display("response_ratio_priority_queue regression: fail");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0] id;
      logic [47:0] base;
      req_chan.valid = 1'b0;
      req_chan.action = '0;
      req_chan.task_id = '0;
      req_chan.now_time = '0;
      req_chan.arrive_ns = '0;
      req_chan.service_ns = '0;
      rsp_chan.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pick, unknown remove, zero burst, extremes, ties, filling the table.
      pending_requests.push_back(make_request(ActPick, 16'h0, 0, 0, 1));
      pending_requests.push_back(make_request(ActRemove, 16'hFFFF, 0, 0, 1));
      pending_requests.push_back(make_request(ActInsert, 16'h1, 100, 0, 0));
      pending_requests.push_back(make_request(ActInsert, 16'hFFFF, Max48, 0, 1));
      pending_requests.push_back(make_request(ActInsert, 16'h0, 0, Max48, 32'hFFFF_FFFF));
      pending_requests.push_back(make_request(ActInsert, 16'h5, 10, 0, 5));
      pending_requests.push_back(make_request(ActInsert, 16'h6, 20, 10, 5));
      pending_requests.push_back(make_request(ActInsert, 16'h5, 7, 7, 3));
      pending_requests.push_back(make_request(ActPick, 16'h0, 0, 0, 0));
      pending_requests.push_back(make_request(ActRemove, 16'hFFFF, 0, 0, 0));
      pending_requests.push_back(make_request(ActPick, 16'h0, 0, 0, 0));
      pending_requests.push_back(make_request(ActRemove, 16'h5, 0, 0, 0));
      pending_requests.push_back(make_request(ActUnused, 16'hABCD, Max48, Max48,
                                              32'hFFFF_FFFF));
      for (int i = 0; i < 12; i++)
         pending_requests.push_back(make_request(ActInsert, 16'(i), 48'(i * 3), 0, 2));
      pending_requests.push_back(make_request(ActInsert, 16'h77, 1, 0, 1));
      pending_requests.push_back(make_request(ActPick, 16'h0, 0, 0, 0));

      // Random: inserts most often, removes of random ids, picks; some noise.
      for (int n = 0; n < 400; n++) begin
         int kind;
         kind = $urandom_range(0, 99);
         id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 31));
         base = rand48();
         if (kind < 45) begin
            logic [31:0] burst;
            case ($urandom_range(0, 5))
               0: burst = $urandom;
               1: burst = 0;
               default: burst = $urandom_range(1, 1000);
            endcase
            pending_requests.push_back(make_request(ActInsert, id,
               ($urandom_range(0, 1)) ? base : 48'($urandom_range(0, 100000)),
               ($urandom_range(0, 4) == 0) ? rand48() : 48'($urandom_range(0, 50000)),
               burst));
         end else if (kind < 75) begin
            pending_requests.push_back(make_request(ActRemove, id, base, rand48(), $urandom));
         end else if (kind < 95) begin
            pending_requests.push_back(make_request(ActPick, id, base, rand48(), $urandom));
         end else begin
            pending_requests.push_back(make_request(ActUnused, id, base, rand48(), $urandom));
         end
      end

      wait (pending_requests.size() == 0 && !req_chan.valid);
      wait (expected_responses.size() == 0);
      repeat (60) @(posedge clock);
      $display("Checked %0d of %0d requests: inserts, removes, picks, unused action.",
               checked, accepted);
      $display("Rejected or flagged responses seen: %0d.", rejects);
      if (errors == 0 && expected_responses.size() == 0) begin
         $display("response_ratio_priority_queue regression: pass");
      end else begin
         $display("response_ratio_priority_queue regression: fail");
      end
      $finish;
   end
endmodule

>>> filelist.f
rtl/rrpq_pkg.sv
rtl/rrpq_if.sv
rtl/rrpq_div.sv
rtl/rrpq_cell.sv
rtl/response_ratio_priority_queue.sv
tb/tb_response_ratio_priority_queue.sv
